// File: src/rpnse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnse_pkg
// Shared types and codes of the reverse-Polish stack evaluator.
// ----------------------------------------------------------------------------
package rpnse_pkg;

    localparam int DataWidth = 32;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_SUB    = 3'd2;
    localparam logic [2:0] ACT_MUL    = 3'd3;
    localparam logic [2:0] ACT_DIV    = 3'd4;
    localparam logic [2:0] ACT_FINISH = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [2:0] STAT_DIVZERO   = 3'd2;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
    localparam logic [2:0] STAT_MALFORMED = 3'd4;

    localparam logic signed [DataWidth-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DataWidth-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]                  action;
        logic signed [DataWidth-1:0] number;
    } rpnse_in_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] top_value;
        logic [2:0]                  status;
        logic [2:0]                  stack_depth;
    } rpnse_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_COMMIT
    } rpnse_state_t;

    typedef struct packed {
        logic load_in;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic commit;
    } rpnse_cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
        logic out_free;
    } rpnse_status_t;

endpackage

// File: src/rpnse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnse_ctrl
// Sequencer: accepts a word, starts multiply or divide when needed, then commits.
// ----------------------------------------------------------------------------
module rpnse_ctrl
    import rpnse_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rpnse_status_t sts,
    output rpnse_cmd_t    cmd
);

    rpnse_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (sts.is_mul)      state_next = S_MUL;
                else if (sts.is_div) state_next = S_DIV;
                else                 state_next = S_COMMIT;
            end
            S_MUL: begin
                state_next = S_COMMIT;
            end
            S_DIV: begin
                if (sts.div_last) state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_DECODE: begin
                cmd.mul_start = sts.is_mul;
                cmd.div_start = sts.is_div;
            end
            S_MUL: begin
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_step_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !cmd.commit && !cmd.load_in)
        else $error("divider step overlaps another command");

    a_div_ends_in_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) && sts.div_last |=> state_reg == S_COMMIT)
        else $error("divide did not finish into commit");

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> state_reg == S_DECODE && !s_ready)
        else $error("accepted word not decoded");

endmodule

// File: src/rpnse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnse_dp
// Operand stack, adder, multiplier, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module rpnse_dp
    import rpnse_pkg::*;
#(
    parameter int STACK_DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rpnse_in_t     s_data,
    input  rpnse_cmd_t    cmd,
    output rpnse_status_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output rpnse_out_t    m_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(DataWidth);

    logic signed [DataWidth-1:0] stk_reg [STACK_DEPTH];
    logic [DW-1:0]               depth_reg, depth_next;
    logic [2:0]                  act_reg;
    logic signed [DataWidth-1:0] num_reg;
    logic signed [63:0]          mul_reg;
    logic                        neg_reg, ovf_reg;
    logic [DataWidth-1:0]        mb_reg, rem_reg, dvd_reg, quo_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        m_valid_reg;
    rpnse_out_t                  m_data_reg;

    logic signed [DataWidth-1:0] a_op, b_op;
    logic                        two_ops;
    logic [DataWidth-1:0]        ma, mb;
    logic [DataWidth:0]          trial;
    logic                        qbit;
    logic signed [DataWidth:0]   sum_w, dif_w;
    logic signed [63:0]          mul_rnd, mul_shf;
    logic signed [DataWidth-1:0] add_sat, sub_sat, mul_sat, div_sat, alu_r;
    logic [2:0]                  res_stat;
    logic signed [DataWidth-1:0] res_top;
    logic                        do_push, do_pop;
    logic [DW+2:0]               depth_ext;

    assign b_op    = stk_reg[0];
    assign a_op    = stk_reg[1];
    assign two_ops = depth_reg >= DW'(2);

    assign sts.is_mul   = (act_reg == ACT_MUL) && two_ops;
    assign sts.is_div   = (act_reg == ACT_DIV) && two_ops && (b_op != '0);
    assign sts.div_last = cnt_reg == CW'(DataWidth - 1);
    assign sts.out_free = !m_valid_reg || m_ready;

    // magnitudes, two's complement of the minimum stays correct unsigned
    assign ma = a_op[DataWidth-1] ? DataWidth'(-a_op) : DataWidth'(a_op);
    assign mb = b_op[DataWidth-1] ? DataWidth'(-b_op) : DataWidth'(b_op);

    assign trial = {rem_reg, dvd_reg[DataWidth-1]};
    assign qbit  = trial >= {1'b0, mb_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= s_data.action;
            num_reg <= s_data.number;
        end
        if (cmd.mul_start) begin
            mul_reg <= 64'(a_op) * 64'(b_op);
        end
        if (cmd.div_start) begin
            neg_reg <= a_op[DataWidth-1] ^ b_op[DataWidth-1];
            ovf_reg <= {16'b0, ma[31:16]} >= mb;
            mb_reg  <= mb;
            rem_reg <= {16'b0, ma[31:16]};
            dvd_reg <= {ma[15:0], 16'b0};
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? DataWidth'(trial - {1'b0, mb_reg}) : trial[DataWidth-1:0];
            dvd_reg <= {dvd_reg[DataWidth-2:0], 1'b0};
            quo_reg <= {quo_reg[DataWidth-2:0], qbit};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // result arithmetic
    always_comb begin
        sum_w   = {a_op[DataWidth-1], a_op} + {b_op[DataWidth-1], b_op};
        dif_w   = {a_op[DataWidth-1], a_op} - {b_op[DataWidth-1], b_op};
        add_sat = (sum_w[DataWidth] != sum_w[DataWidth-1]) ?
                  (sum_w[DataWidth] ? Q_MIN : Q_MAX) : sum_w[DataWidth-1:0];
        sub_sat = (dif_w[DataWidth] != dif_w[DataWidth-1]) ?
                  (dif_w[DataWidth] ? Q_MIN : Q_MAX) : dif_w[DataWidth-1:0];
        mul_rnd = mul_reg + 64'sd32768;
        mul_shf = mul_rnd >>> 16;
        if ((&mul_shf[63:31]) || !(|mul_shf[63:31])) begin
            mul_sat = mul_shf[DataWidth-1:0];
        end else begin
            mul_sat = mul_shf[63] ? Q_MIN : Q_MAX;
        end
        if (neg_reg) begin
            div_sat = (ovf_reg || quo_reg[DataWidth-1]) ? Q_MIN : DataWidth'(-quo_reg);
        end else begin
            div_sat = (ovf_reg || quo_reg[DataWidth-1]) ? Q_MAX : quo_reg;
        end
        unique case (act_reg)
            ACT_ADD: alu_r = add_sat;
            ACT_SUB: alu_r = sub_sat;
            ACT_MUL: alu_r = mul_sat;
            default: alu_r = div_sat;
        endcase
    end

    // stack update and status
    always_comb begin
        res_stat   = STAT_OK;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        depth_next = depth_reg;
        res_top    = (depth_reg != '0) ? stk_reg[0] : '0;
        unique case (act_reg)
            ACT_PUSH: begin
                if (depth_reg >= DW'(STACK_DEPTH)) begin
                    res_stat = STAT_OVERFLOW;
                end else begin
                    do_push    = 1'b1;
                    depth_next = depth_reg + DW'(1);
                    res_top    = num_reg;
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (!two_ops) begin
                    res_stat = STAT_UNDERFLOW;
                end else if ((act_reg == ACT_DIV) && (b_op == '0)) begin
                    res_stat = STAT_DIVZERO;
                end else begin
                    do_pop     = 1'b1;
                    depth_next = depth_reg - DW'(1);
                    res_top    = alu_r;
                end
            end
            ACT_FINISH: begin
                if (depth_reg != DW'(1)) begin
                    res_stat = STAT_MALFORMED;
                end else begin
                    depth_next = '0;
                    res_top    = stk_reg[0];
                end
            end
            default: begin
            end
        endcase
        if (res_stat != STAT_OK) begin
            do_push    = 1'b0;
            do_pop     = 1'b0;
            depth_next = '0;
            res_top    = '0;
        end
    end

    assign depth_ext = {3'b0, depth_next};

    always_ff @(posedge aclk) begin
        if (cmd.commit && do_push) begin
            stk_reg[0] <= num_reg;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (cmd.commit && do_pop) begin
            stk_reg[0] <= alu_r;
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
        if (cmd.commit) begin
            m_data_reg.top_value   <= res_top;
            m_data_reg.status      <= res_stat;
            m_data_reg.stack_depth <= depth_ext[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                depth_reg <= depth_next;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_depth_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before delivery");

    a_fault_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (res_stat != STAT_OK) |=> depth_reg == '0 && m_valid_reg)
        else $error("fault did not clear the stack");

    a_no_work_while_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !cmd.mul_start && !cmd.div_start)
        else $error("divider restarted mid-operation");

endmodule

// File: src/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-Polish evaluator on a shift-register operand stack in Q16.16.
// ----------------------------------------------------------------------------
// usage:
//   s_valid/s_ready/s_data carry one token word: action and number.
//   m_valid/m_ready/m_data return one result word per token: stack top,
//   status and depth after the token.
//   from accept, push, add, subtract, finish and faults pass decode and
//   commit; multiply adds a registered product, rounded at commit; divide
//   adds setup and 32 radix-2 quotient steps before commit.
//   one token is in flight at a time; the next token is accepted the cycle
//   after its result is committed to the output register.
//   a stalled receiver holds m_data; the next token is still accepted and
//   worked, and its commit waits until the output register is free.
//   reset clears the depth and the output valid; stack entries need none.
//   faults report a status, return top 0 and depth 0 and empty the stack.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator
    import rpnse_pkg::*;
#(
    parameter int STACK_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rpnse_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rpnse_out_t m_data
);

    rpnse_cmd_t    cmd;
    rpnse_status_t sts;

    rpnse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rpnse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
